FILE: hw/rtl/button_debounce_hold_detector_unit_defines.svh
// Assertion helpers shared by the debounce unit
`ifndef BUTTON_DEBOUNCE_HOLD_DETECTOR_UNIT_DEFINES_SVH
`define BUTTON_DEBOUNCE_HOLD_DETECTOR_UNIT_DEFINES_SVH

// Check on every clock edge outside reset
`define BDHD_ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included
`define BDHD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/bdhd_pkg.sv
`timescale 1ns / 1ps

package bdhd_pkg;

  // Reported button state
  typedef enum logic [1:0] {
    BS_RELEASED = 2'd0,
    BS_PRESSED  = 2'd1,
    BS_HELD     = 2'd2
  } btn_state_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_DB_PERIOD  = 2'd0;
  localparam logic [1:0] CFG_HOLD_TIME  = 2'd1;
  localparam logic [1:0] CFG_EVENT_CODE = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Reset values of the registers
  localparam logic [15:0]        DB_PERIOD_RST  = 16'd50;
  localparam logic signed [16:0] HOLD_TIME_RST  = 17'sd1000;
  localparam logic [7:0]         EVENT_CODE_RST = 8'd0;

  // Debounce timer idle mark
  localparam logic signed [17:0] DB_TIMER_IDLE = -18'sd1;

  typedef struct packed {
    logic [15:0]        db_period;
    logic signed [16:0] hold_time;
    logic [7:0]         event_code;
  } cfg_t;

  // One emitted event
  typedef struct packed {
    logic       valid;
    logic [7:0] code;
    btn_state_t state;
  } evt_t;

endpackage

FILE: hw/rtl/button_debounce_hold_detector_unit.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-----------------------------------
// in_      | slave     | in_tvalid/tready   | tdata: pin_level, delta_time
// out_     | master    | out_tvalid/tready  | tdata: code, button_state
// cfg_     | write     | cfg_we             | cfg_idx, cfg_wdata
//
// One tick is taken per cycle while the output is not stalled; a result passes from its input
// transaction through the input register and then the output register.
// Ticks that change no state give no output transaction.
// rst_n is synchronous: all state returns to released with the timers idle.
// A stalled output holds the input register, and in_tready drops with it.
`timescale 1ns / 1ps
`include "button_debounce_hold_detector_unit_defines.svh"

module button_debounce_hold_detector_unit
  import bdhd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // tdata: [0] pin_level, [16:1] delta_time, [23:17] zero
  input  logic [23:0]           in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata: [7:0] code, [9:8] button_state, [15:10] zero
  output logic [15:0]           out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t        cfg;
  evt_t        evt;
  logic        in_valid_r;
  logic        in_pin_r;
  logic [15:0] in_dt_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_code_r;
  btn_state_t  out_state_r;
  logic        advance;
  logic        in_blocked;

  bdhd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Move the registered tick on when the output register can take a result
  assign advance    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;
  assign in_blocked = in_valid_r && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_pin_r <= in_tdata[0];
      in_dt_r  <= in_tdata[16:1];
    end
  end

  bdhd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .step       (advance),
    .pin_level  (in_pin_r),
    .delta_time (in_dt_r),
    .evt        (evt)
  );

  // Output register
  assign out_valid_nxt = advance ? evt.valid : (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && evt.valid) begin
      out_code_r  <= evt.code;
      out_state_r <= evt.state;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_state_r, out_code_r};

  // A blocked tick stays in the input register unchanged
  `BDHD_ASSERT_ON(a_in_hold, in_blocked |=> in_valid_r && $stable(in_dt_r), "tick lost")
  // A result only appears after a tick was moved on
  `BDHD_ASSERT_ON(a_out_source, $rose(out_valid_r) |-> $past(in_valid_r), "result without tick")
  // With no new transaction the input register drains
  `BDHD_ASSERT_ON(a_in_drain, (in_tready && !in_tvalid) |=> !in_valid_r, "not drained")
  // Reset empties both registers
  `BDHD_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !in_valid_r && !out_valid_r, "busy after reset")

endmodule

FILE: hw/rtl/bdhd_cfg.sv
`timescale 1ns / 1ps

module bdhd_cfg
  import bdhd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  // Write one register per transaction; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.db_period  <= DB_PERIOD_RST;
      cfg_r.hold_time  <= HOLD_TIME_RST;
      cfg_r.event_code <= EVENT_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_DB_PERIOD:  cfg_r.db_period  <= cfg_wdata[15:0];
        CFG_HOLD_TIME:  cfg_r.hold_time  <= $signed(cfg_wdata[16:0]);
        CFG_EVENT_CODE: cfg_r.event_code <= cfg_wdata[7:0];
        default:        ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/bdhd_core.sv
`timescale 1ns / 1ps
`include "button_debounce_hold_detector_unit_defines.svh"

module bdhd_core
  import bdhd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        step,
  input  logic        pin_level,
  input  logic [15:0] delta_time,
  output evt_t        evt
);

  logic signed [17:0] db_timer_r, db_timer_nxt;
  logic               accepted_level_r, accepted_level_nxt;
  logic               reported_level_r, reported_level_nxt;
  logic [31:0]        hold_timer_r, hold_timer_nxt;
  btn_state_t         cur_state_r, cur_state_nxt;

  logic signed [17:0] limit;
  logic signed [17:0] timer_adv;
  logic               pressed;
  logic               held;
  logic               update;
  btn_state_t         cand_state;
  logic [32:0]        hold_sum;

  assign limit = $signed({2'b00, cfg.db_period});

  // Debounce, level acceptance and hold timer
  always_comb begin
    timer_adv = db_timer_r;
    if (!db_timer_r[17] && (db_timer_r < limit))
      timer_adv = db_timer_r + $signed({2'b00, delta_time});

    if (pin_level != reported_level_r)
      db_timer_nxt = timer_adv[17] ? 18'sd0 : timer_adv;
    else
      db_timer_nxt = DB_TIMER_IDLE;

    accepted_level_nxt = (db_timer_nxt >= limit) ? pin_level : accepted_level_r;

    pressed = !accepted_level_nxt;
    held    = pressed && !cfg.hold_time[16]
              && (hold_timer_r > {16'd0, cfg.hold_time[15:0]});

    hold_sum = {1'b0, hold_timer_r} + {17'd0, delta_time};
    if (!pressed)
      hold_timer_nxt = '0;
    else if (hold_sum[32])
      hold_timer_nxt = '1;
    else
      hold_timer_nxt = hold_sum[31:0];
  end

  // Next button state
  always_comb begin
    update        = (reported_level_r != accepted_level_nxt) || held;
    cand_state    = held ? BS_HELD : (pressed ? BS_PRESSED : BS_RELEASED);
    cur_state_nxt = update ? cand_state : cur_state_r;
  end

  // Event output and reported level
  always_comb begin
    evt.valid          = step && (cur_state_nxt != cur_state_r);
    evt.code           = cfg.event_code;
    evt.state          = cur_state_nxt;
    reported_level_nxt = (cur_state_nxt != cur_state_r)
                         ? accepted_level_nxt : reported_level_r;
  end

  // Advance the state once per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_timer_r       <= DB_TIMER_IDLE;
      accepted_level_r <= 1'b1;
      reported_level_r <= 1'b1;
      hold_timer_r     <= '0;
      cur_state_r      <= BS_RELEASED;
    end else if (step) begin
      db_timer_r       <= db_timer_nxt;
      accepted_level_r <= accepted_level_nxt;
      reported_level_r <= reported_level_nxt;
      hold_timer_r     <= hold_timer_nxt;
      cur_state_r      <= cur_state_nxt;
    end
  end

  // A change of accepted level always ends in a reported event
  `BDHD_ASSERT_ON(a_levels_agree, accepted_level_r == reported_level_r, "level not reported")
  // Pressed or held implies the accepted level is low
  `BDHD_ASSERT_ON(a_state_level, (cur_state_r != BS_RELEASED) |-> !accepted_level_r, "bad level")
  // An event always carries a new state
  `BDHD_ASSERT_ON(a_evt_changes, evt.valid |=> !$stable(cur_state_r), "event without state change")

endmodule

FILE: verif/button_debounce_hold_detector_unit_tb.sv
`timescale 1ns / 1ps

module button_debounce_hold_detector_unit_tb;
  import bdhd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int PHASE_TICKS      = 100;
  localparam int PHASE_COUNT      = 8;
  localparam int SETTLE_TICKS     = 8;
  localparam int QUIET_LIMIT      = 2000;
  localparam int LONG_PRESS_TICKS = 20;

  typedef struct {
    logic [7:0] code;
    btn_state_t state;
  } btn_event_t;

  logic                  clk;
  logic                  rst_n;
  // tdata: [0] pin_level, [16:1] delta_time, [23:17] zero
  logic [23:0]           in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  // tdata: [7:0] code, [9:8] button_state, [15:10] zero
  logic [15:0]           out_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Button model state and its copy of the registers
  cfg_t               cfg_model;
  logic signed [17:0] db_timer;
  logic               acc_level;
  logic               rep_level;
  logic [31:0]        hold_timer;
  btn_state_t         btn_state;

  btn_event_t pending_events[$];
  int         mismatch_count;
  int         quiet_cycles;
  logic       stall_enable;

  button_debounce_hold_detector_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic reset_button_model();
    cfg_model.db_period  = DB_PERIOD_RST;
    cfg_model.hold_time  = HOLD_TIME_RST;
    cfg_model.event_code = EVENT_CODE_RST;
    db_timer   = DB_TIMER_IDLE;
    acc_level  = 1'b1;
    rep_level  = 1'b1;
    hold_timer = '0;
    btn_state  = BS_RELEASED;
  endtask

  // Step the model by one tick and queue the event it causes, if any
  task automatic advance_button_model(input logic pin, input logic [15:0] dt);
    logic signed [17:0] limit;
    logic               pressed;
    logic               held;
    btn_state_t         prev;
    logic [32:0]        hold_sum;
    btn_event_t         evt;
    limit = $signed({2'b00, cfg_model.db_period});
    // advance the debounce timer only while it is below the limit
    if (db_timer >= 0 && db_timer < limit)
      db_timer = db_timer + $signed({2'b00, dt});
    if (pin != rep_level) begin
      if (db_timer < 0)
        db_timer = 18'sd0;
    end else begin
      db_timer = DB_TIMER_IDLE;
    end
    if (db_timer >= limit)
      acc_level = pin;

    // decide the new state; a negative hold time disables hold
    pressed = !acc_level;
    held = pressed && !cfg_model.hold_time[16] &&
           (hold_timer > {15'd0, cfg_model.hold_time});
    if (rep_level != acc_level || held) begin
      prev = btn_state;
      btn_state = held ? BS_HELD : (pressed ? BS_PRESSED : BS_RELEASED);
      if (btn_state != prev) begin
        evt.code  = cfg_model.event_code;
        evt.state = btn_state;
        pending_events.push_back(evt);
        rep_level = acc_level;
      end
    end

    // accumulate pressed time, saturating at the top
    if (pressed) begin
      hold_sum   = {1'b0, hold_timer} + {17'd0, dt};
      hold_timer = hold_sum[32] ? 32'hFFFF_FFFF : hold_sum[31:0];
    end else begin
      hold_timer = '0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Send one tick and wait for its transaction; then maybe pause
  task automatic send_tick(input logic pin, input logic [15:0] dt);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, dt, pin};
    do @(posedge clk); while (!in_tready);
    advance_button_model(pin, dt);
    if (stall_enable && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Hold off the sender until every expected event is out
  task automatic drain_events();
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_DB_PERIOD:  cfg_model.db_period  = data[15:0];
      CFG_HOLD_TIME:  cfg_model.hold_time  = data;
      CFG_EVENT_CODE: cfg_model.event_code = data[7:0];
      default: ;
    endcase
  endtask

  // Write all registers, with junk in the unused upper bits of the period and code writes, plus a stray index
  task automatic apply_config(input logic [15:0] db, input logic signed [16:0] hold,
                              input logic [7:0] code);
    write_reg(CFG_DB_PERIOD, {1'($urandom), db});
    write_reg(CFG_HOLD_TIME, hold);
    write_reg(CFG_EVENT_CODE, {9'($urandom), code});
    write_reg(CFG_UNUSED_IDX, 17'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Press with a bounce, hold, release with a bounce, at reset settings
  task automatic test_press_hold_release();
    send_tick(1'b0, 16'd10);
    send_tick(1'b1, 16'd5);
    send_tick(1'b0, 16'd30);
    send_tick(1'b0, 16'd30);
    send_tick(1'b0, 16'd30);
    send_tick(1'b0, 16'd1000);
    send_tick(1'b0, 16'd0);
    send_tick(1'b0, 16'hFFFF);
    send_tick(1'b1, 16'd0);
    send_tick(1'b0, 16'd7);
    send_tick(1'b1, 16'd0);
    send_tick(1'b1, 16'd50);
    send_tick(1'b1, 16'hFFFF);
    drain_events();
  endtask

  // Zero and full debounce time, hold disabled, hold at zero and at its top
  task automatic test_register_extremes();
    apply_config(16'd0, -17'sd1, 8'hFF);
    send_tick(1'b0, 16'd0);
    send_tick(1'b0, 16'hFFFF);
    send_tick(1'b0, 16'd0);
    send_tick(1'b1, 16'hFFFF);
    drain_events();
    apply_config(16'hFFFF, 17'sd65535, 8'h5A);
    send_tick(1'b0, 16'd0);
    send_tick(1'b0, 16'hFFFE);
    send_tick(1'b0, 16'hFFFF);
    send_tick(1'b0, 16'hFFFF);
    send_tick(1'b0, 16'd1);
    send_tick(1'b1, 16'hFFFF);
    send_tick(1'b1, 16'hFFFF);
    drain_events();
    apply_config(16'd1, 17'sd0, 8'h01);
    send_tick(1'b0, 16'd1);
    send_tick(1'b0, 16'd1);
    send_tick(1'b0, 16'd0);
    send_tick(1'b1, 16'd0);
    send_tick(1'b1, 16'd1);
    drain_events();
  endtask

  // Run a long press with hold off, then enable hold while still pressed
  task automatic test_long_press();
    stall_enable = 1'b0;
    apply_config(16'd0, -17'sd1, 8'h3C);
    send_tick(1'b0, 16'd0);
    repeat (LONG_PRESS_TICKS) send_tick(1'b0, 16'hFFFF);
    drain_events();
    apply_config(16'd0, 17'sd65535, 8'h3C);
    send_tick(1'b0, 16'd0);
    send_tick(1'b1, 16'd0);
    drain_events();
    stall_enable = 1'b1;
  endtask

  // Bouncy press and release runs over a series of settings
  task automatic test_random_phases();
    logic [15:0]        db;
    logic signed [16:0] hold;
    logic               level;
    logic               pin;
    int                 dt_cap;
    int                 sent;
    int                 run;
    level = 1'b1;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      // pick the settings: extremes first, then random picks
      case (phase)
        0: db = 16'd0;
        1: db = 16'hFFFF;
        2: db = 16'd1;
        default: begin
          case ($urandom_range(0, 2))
            0: db = 16'($urandom_range(2, 20));
            1: db = 16'($urandom_range(100, 2000));
            default: db = 16'($urandom_range(0, 65535));
          endcase
        end
      endcase
      dt_cap = (db >> 1) + 1;
      case (phase)
        0: hold = -17'sd1;
        1: hold = 17'sd65535;
        2: hold = 17'sd0;
        default: begin
          case ($urandom_range(0, 3))
            0: hold = -17'sd1 - 17'($urandom_range(0, 65535));
            1: hold = 17'($urandom_range(0, 65535));
            default: hold = 17'($urandom_range(0, dt_cap * 4));
          endcase
        end
      endcase
      stall_enable = (phase != PHASE_COUNT - 1);
      apply_config(db, hold, 8'($urandom));

      sent = 0;
      while (sent < PHASE_TICKS) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise tick
          send_tick(1'($urandom), 16'($urandom));
          sent++;
        end else begin
          // run toward the other level with occasional bounces
          level = ~level;
          run = $urandom_range(2, 10);
          repeat (run) begin
            pin = ($urandom_range(0, 4) == 0) ? ~level : level;
            send_tick(pin, 16'($urandom_range(0, dt_cap)));
            sent++;
          end
        end
        if (stall_enable && $urandom_range(0, 40) == 0)
          drain_events();
      end
      drain_events();
    end
  endtask

  // Receiver pacing: random stall bursts while enabled
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_enable && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Compare each output transaction with the oldest expected event
  always @(posedge clk) begin : check_events
    btn_event_t exp_evt;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event tdata=%h", out_tdata));
      end else begin
        exp_evt = pending_events.pop_front();
        if (out_tdata[7:0] !== exp_evt.code)
          report_mismatch($sformatf("code %h, expected %h", out_tdata[7:0], exp_evt.code));
        if (out_tdata[9:8] !== exp_evt.state)
          report_mismatch($sformatf("button_state %0d, expected %0d",
                                    out_tdata[9:8], exp_evt.state));
        if (out_tdata[15:10] !== '0)
          report_mismatch($sformatf("padding bits %h not zero", out_tdata[15:10]));
      end
    end
  end

  // Count cycles with no transaction anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    cfg_we         <= 1'b0;
    cfg_idx        <= '0;
    cfg_wdata      <= '0;
    rst_n          <= 1'b0;
    quiet_cycles   = 0;
    mismatch_count = 0;
    stall_enable   = 1'b1;
    reset_button_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_press_hold_release();
    test_register_extremes();
    test_long_press();
    test_random_phases();
    drain_events();

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
